[rtl/assert_macros.svh]
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/qeg_pkg.sv]
// types and constants of the quadrature encoder generator
package qeg_pkg;

   localparam int CHAN_W = 3;
   localparam int ACC_W  = 32;
   localparam int CNT_W  = 16;
   localparam int QUAD_W = 2;

   localparam logic [CNT_W-1:0] PPR_RESET = 16'd100;

   localparam logic [QUAD_W-1:0] QUAD_FIRST = 2'd0;
   localparam logic [QUAD_W-1:0] QUAD_LAST  = 2'd3;

   // per-channel encoder state as held in the state ram
   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic [QUAD_W-1:0] quad;
      logic [CNT_W-1:0]  cnt;
   } entry_type;

   // write-back port of the state ram
   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] chan;
      entry_type         data;
   } wr_type;

   // encoder outputs for one item
   typedef struct packed {
      logic phase_a;
      logic phase_b;
      logic index_pulse;
   } pins_type;

endpackage

[rtl/qeg_if.sv]
// handshake channels of the quadrature encoder generator

interface qeg_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        channel;
   logic signed [31:0] rate;

   modport source (output valid, output channel, output rate, input ready);
   modport sink   (input valid, input channel, input rate, output ready);
endinterface

interface qeg_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_channel;
   logic       phase_a;
   logic       phase_b;
   logic       index_pulse;

   modport source (output valid, output out_channel, output phase_a, output phase_b,
                   output index_pulse, input ready);
   modport sink   (input valid, input out_channel, input phase_a, input phase_b,
                   input index_pulse, output ready);
endinterface

interface qeg_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] pulses_per_rev;

   modport source (output valid, output pulses_per_rev, input ready);
   modport sink   (input valid, input pulses_per_rev, output ready);
endinterface

[rtl/quadrature_encoder_generator.sv]
// Quadrature encoder generator: takes one tick item per clock on req_port while the pipeline is
// not stalled and presents each result item on rsp_port from the output register, behind s1. Each
// tick reads its channel's state from a CHANNELS-entry state ram as it is accepted, updates
// accumulator, quadrature state and revolution counter from the registered read and writes the entry
// back as the result is registered; a tick that follows one on the same channel takes the
// written-back state by forwarding, so the single ram read and write port pair sets the rate of
// one item per clock. Channels at or above CHANNELS return all outputs low and keep no state.
// The pulses_per_rev register is written through csr_port, which is always ready.
module quadrature_encoder_generator #(
   parameter int CHANNELS = 8
) (
   input  logic  clock,
   input  logic  reset,
   qeg_req_if.sink   req_port,
   qeg_rsp_if.source rsp_port,
   qeg_csr_if.sink   csr_port
);
   import qeg_pkg::*;

   `include "assert_macros.svh"

   logic [CNT_W-1:0]  ppr_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0] s1_chan_ff;
   logic [ACC_W-1:0]  s1_rate_ff;
   logic              fwd_hit_ff;
   entry_type         fwd_data_ff;

   logic              out_valid_ff, out_valid_in;
   logic [CHAN_W-1:0] out_chan_ff;
   pins_type          out_pins_ff;

   logic              req_acc;
   logic              s1_fire;
   logic              s1_present;
   entry_type         rd_data;
   entry_type         cur;
   entry_type         nxt;
   pins_type          pins;
   wr_type            wr;

   assign s1_fire        = s1_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || s1_fire;
   assign req_acc        = req_port.valid && req_port.ready;
   assign s1_present     = int'(s1_chan_ff) < CHANNELS;

   assign csr_port.ready = 1'b1;

   qeg_state_mem #(
      .DEPTH (CHANNELS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_chan (req_port.channel),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // the previous tick's write-back lands at the edge of our read
   assign cur = fwd_hit_ff ? fwd_data_ff : rd_data;

   qeg_update u_update (
      .cur  (cur),
      .rate (s1_rate_ff),
      .ppr  (ppr_ff),
      .nxt  (nxt),
      .pins (pins)
   );

   assign wr.en   = s1_fire && s1_present;
   assign wr.chan = s1_chan_ff;
   assign wr.data = nxt;

   assign s1_valid_in  = req_acc || (s1_valid_ff && !s1_fire);
   assign out_valid_in = s1_fire || (out_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff       <= PPR_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         if (csr_port.valid) begin
            ppr_ff <= csr_port.pulses_per_rev;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (req_acc) begin
            fwd_hit_ff <= wr.en && (wr.chan == req_port.channel);
         end else if (s1_fire) begin
            fwd_hit_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_chan_ff  <= req_port.channel;
         s1_rate_ff  <= req_port.rate;
         fwd_data_ff <= nxt;
      end
      if (s1_fire) begin
         out_chan_ff <= s1_chan_ff;
         out_pins_ff <= s1_present ? pins : '0;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.out_channel = out_chan_ff;
   assign rsp_port.phase_a     = out_pins_ff.phase_a;
   assign rsp_port.phase_b     = out_pins_ff.phase_b;
   assign rsp_port.index_pulse = out_pins_ff.index_pulse;

   `ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_acc, s1_valid_ff)
   `ASSERT_IMPLIES(a_fwd_needs_item, clock, reset, fwd_hit_ff, s1_valid_ff)
   `ASSERT_IMPLIES(a_absent_low, clock, reset,
                   out_valid_ff && (int'(out_chan_ff) >= CHANNELS),
                   !rsp_port.phase_a && !rsp_port.phase_b && !rsp_port.index_pulse)
   `ASSERT_IMPLIES(a_index_in_state0, clock, reset,
                   out_valid_ff && rsp_port.index_pulse,
                   rsp_port.phase_a && !rsp_port.phase_b)

endmodule

[rtl/qeg_state_mem.sv]
// per-channel state ram with registered read and reset valid bits
module qeg_state_mem #(
   parameter int DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [qeg_pkg::CHAN_W-1:0]  rd_chan,
   input  qeg_pkg::wr_type             wr,
   output qeg_pkg::entry_type          rd_data
);
   import qeg_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type        state_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   entry_type        rd_raw_ff;
   logic             rd_valid_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   assign rd_addr = rd_chan[AW-1:0];
   assign wr_addr = wr.chan[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         state_mem[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_raw_ff <= state_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as the reset state
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

[rtl/qeg_update.sv]
// one tick of encoder state: accumulate, step quadrature, step revolution counter
module qeg_update (
   input  qeg_pkg::entry_type             cur,
   input  logic signed [qeg_pkg::ACC_W-1:0] rate,
   input  logic [qeg_pkg::CNT_W-1:0]      ppr,
   output qeg_pkg::entry_type             nxt,
   output qeg_pkg::pins_type              pins
);
   import qeg_pkg::*;

   logic [ACC_W-1:0]  acc_sum;
   logic              crossed;
   logic              down;
   logic [CNT_W:0]    modulus;
   logic [CNT_W-1:0]  mod_minus_one;
   logic [CNT_W:0]    cnt_plus_one;
   logic [CNT_W-1:0]  cnt_up;
   logic [CNT_W-1:0]  cnt_down;

   assign acc_sum = cur.acc + rate;
   assign crossed = acc_sum[ACC_W-1] != cur.acc[ACC_W-1];
   assign down    = rate[ACC_W-1];

   // zero modulus wraps through the full counter range
   assign modulus       = (ppr == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, ppr};
   assign mod_minus_one = ppr - 1'b1;
   assign cnt_plus_one  = {1'b0, cur.cnt} + 1'b1;
   assign cnt_up        = (cnt_plus_one >= modulus) ? '0 : cnt_plus_one[CNT_W-1:0];
   assign cnt_down      = (cur.cnt == '0 || {1'b0, cur.cnt} >= modulus) ?
                          mod_minus_one : cur.cnt - 1'b1;

   always_comb begin
      nxt     = cur;
      nxt.acc = acc_sum;
      if (crossed) begin
         if (down) begin
            nxt.quad = cur.quad - 1'b1;
            if (cur.quad == QUAD_FIRST) begin
               nxt.cnt = cnt_down;
            end
         end else begin
            nxt.quad = cur.quad + 1'b1;
            if (cur.quad == QUAD_LAST) begin
               nxt.cnt = cnt_up;
            end
         end
      end
   end

   assign pins.phase_a     = (nxt.quad == 2'd0) || (nxt.quad == 2'd1);
   assign pins.phase_b     = (nxt.quad == 2'd1) || (nxt.quad == 2'd2);
   assign pins.index_pulse = (nxt.quad == QUAD_FIRST) && (nxt.cnt == '0);

endmodule

[tb/tb_top.sv]
// self-checking testbench of the quadrature encoder generator
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qeg_pkg::*;

   localparam int TB_CHANNELS = 8;
   localparam int STALL_PCT   = 15;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      pins_type          pins;
   } tick_result_type;

   logic clock;
   logic reset;

   qeg_req_if req_ch ();
   qeg_rsp_if rsp_ch ();
   qeg_csr_if csr_ch ();

   quadrature_encoder_generator #(
      .CHANNELS(TB_CHANNELS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   // encoder state as the block should hold it
   logic [ACC_W-1:0]  enc_acc  [TB_CHANNELS];
   logic [QUAD_W-1:0] enc_quad [TB_CHANNELS];
   logic [CNT_W-1:0]  enc_rev  [TB_CHANNELS];
   logic [CNT_W-1:0]  enc_ppr;

   tick_result_type pending_pins_q[$];

   int error_count = 0;
   int hold_left   = 0;
   bit no_idle     = 1'b0;
   bit req_active  = 1'b0;
   logic [CHAN_W-1:0] last_chan = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("quadrature_encoder_generator regression: fail");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("error: %s", msg);
      error_count++;
   endtask

   function automatic logic [CNT_W-1:0] next_rev_count(logic [CNT_W-1:0] cnt, bit down);
      logic [CNT_W:0] m;
      logic [CNT_W:0] c;
      // a zero register means the full 16-bit range
      m = (enc_ppr == '0) ? (17'd1 << CNT_W) : {1'b0, enc_ppr};
      c = {1'b0, cnt};
      if (down)
         c = (c == '0 || c >= m) ? m - 17'd1 : c - 17'd1;
      else
         c = (c + 17'd1 >= m) ? '0 : c + 17'd1;
      return c[CNT_W-1:0];
   endfunction

   function automatic tick_result_type predict_pins(logic [CHAN_W-1:0] chan,
                                                    logic [ACC_W-1:0] tick_rate);
      tick_result_type r;
      logic [ACC_W-1:0] sum;
      logic [QUAD_W-1:0] q;
      r = '0;
      r.chan = chan;
      if (int'(chan) >= TB_CHANNELS)
         return r;
      sum = enc_acc[chan] + tick_rate;
      if (sum[ACC_W-1] != enc_acc[chan][ACC_W-1]) begin
         q = enc_quad[chan];
         if (tick_rate[ACC_W-1]) begin
            if (q == QUAD_FIRST) begin
               q = QUAD_LAST;
               enc_rev[chan] = next_rev_count(enc_rev[chan], 1'b1);
            end else begin
               q = q - 2'd1;
            end
         end else begin
            if (q == QUAD_LAST) begin
               q = QUAD_FIRST;
               enc_rev[chan] = next_rev_count(enc_rev[chan], 1'b0);
            end else begin
               q = q + 2'd1;
            end
         end
         enc_quad[chan] = q;
      end
      enc_acc[chan] = sum;
      q = enc_quad[chan];
      r.pins.phase_a     = (q == 2'd0 || q == 2'd1);
      r.pins.phase_b     = (q == 2'd1 || q == 2'd2);
      r.pins.index_pulse = (q == QUAD_FIRST && enc_rev[chan] == '0);
      return r;
   endfunction

   // receiver: random stalls, a counted hold-off when asked, or always ready under no_idle
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (no_idle) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= STALL_PCT);
         end
      end
   end

   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pins_q.size() == 0) begin
            report_mismatch($sformatf("result item on channel %0d with nothing expected",
                                      rsp_ch.out_channel));
         end else begin
            want = pending_pins_q.pop_front();
            if (rsp_ch.out_channel !== want.chan)
               report_mismatch($sformatf("out_channel got %0d expected %0d",
                                         rsp_ch.out_channel, want.chan));
            if (rsp_ch.phase_a !== want.pins.phase_a)
               report_mismatch($sformatf("channel %0d phase_a got %b expected %b",
                                         want.chan, rsp_ch.phase_a, want.pins.phase_a));
            if (rsp_ch.phase_b !== want.pins.phase_b)
               report_mismatch($sformatf("channel %0d phase_b got %b expected %b",
                                         want.chan, rsp_ch.phase_b, want.pins.phase_b));
            if (rsp_ch.index_pulse !== want.pins.index_pulse)
               report_mismatch($sformatf("channel %0d index_pulse got %b expected %b",
                                         want.chan, rsp_ch.index_pulse,
                                         want.pins.index_pulse));
         end
      end
   end

   task automatic stop_ticks();
      if (req_active) begin
         req_ch.valid <= 1'b0;
         req_active = 1'b0;
      end
   endtask

   // valid stays high after the item so that the next one follows without a gap
   task automatic send_tick(logic [CHAN_W-1:0] chan, logic [ACC_W-1:0] tick_rate);
      if (!no_idle && $urandom_range(99) < STALL_PCT) begin
         stop_ticks();
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.channel <= chan;
      req_ch.rate    <= tick_rate;
      req_active = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_pins_q.push_back(predict_pins(chan, tick_rate));
      last_chan = chan;
   endtask

   task automatic wait_drained();
      stop_ticks();
      while (pending_pins_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_pulses_per_rev(logic [CNT_W-1:0] ppr);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_ch.valid          <= 1'b1;
      csr_ch.pulses_per_rev <= ppr;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      enc_ppr = ppr;
   endtask

   function automatic logic [ACC_W-1:0] pick_rate();
      int unsigned sel;
      logic [ACC_W-1:0] mag;
      sel = $urandom_range(99);
      if (sel < 40)
         mag = 32'h4000_0000 - $urandom_range(0, 32'h0FFF_FFFF);
      else if (sel < 60)
         mag = $urandom();
      else if (sel < 75)
         mag = $urandom_range(0, 65535);
      else if (sel < 85)
         return '0;
      else begin
         case ($urandom_range(3))
            0: mag = 32'h8000_0000;
            1: mag = 32'h7FFF_FFFF;
            2: mag = 32'hFFFF_FFFF;
            default: mag = 32'h4000_0000;
         endcase
         return mag;
      end
      return $urandom_range(1) ? mag : -mag;
   endfunction

   function automatic logic [CHAN_W-1:0] pick_chan();
      // runs on one channel exercise the back-to-back path
      if ($urandom_range(1))
         return last_chan;
      return CHAN_W'($urandom_range(TB_CHANNELS - 1));
   endfunction

   task automatic run_random_ticks(int count);
      repeat (count) send_tick(pick_chan(), pick_rate());
   endtask

   task automatic test_reset_state();
      send_tick(3'd0, 32'd0);
      send_tick(3'd7, 32'd0);
   endtask

   task automatic test_rate_extremes();
      repeat (4) send_tick(3'd1, 32'h4000_0000);
      repeat (2) send_tick(3'd1, 32'hC000_0000);
      repeat (2) send_tick(3'd1, 32'h8000_0000);
      send_tick(3'd1, 32'h7FFF_FFFF);
      send_tick(3'd1, 32'hFFFF_FFFF);
      send_tick(3'd1, 32'd1);
      send_tick(3'd1, 32'd0);
   endtask

   task automatic test_zero_modulus();
      set_pulses_per_rev(16'd0);
      repeat (3) send_tick(3'd2, 32'h8000_0000);
   endtask

   task automatic test_counter_out_of_range();
      // counter of channel 2 now sits at or above the new modulus
      set_pulses_per_rev(16'hFFFF);
      repeat (2) send_tick(3'd2, 32'h8000_0000);
      set_pulses_per_rev(16'd1);
      repeat (2) send_tick(3'd2, 32'h8000_0000);
      send_tick(3'd2, 32'h7FFF_FFFF);
   endtask

   task automatic test_output_hold_off();
      hold_left = 80;
      run_random_ticks(40);
      wait_drained();
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      run_random_ticks(60);
      no_idle = 1'b0;
   endtask

   task automatic test_random_settings();
      logic [CNT_W-1:0] ppr_list [8];
      ppr_list = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd0, 16'd7, 16'd4, 16'd100};
      ppr_list[6] = CNT_W'($urandom_range(1, 12));
      ppr_list[7] = CNT_W'($urandom());
      foreach (ppr_list[i]) begin
         set_pulses_per_rev(ppr_list[i]);
         run_random_ticks(17);
         // sender waits for every result before going on
         wait_drained();
         run_random_ticks(18);
      end
   endtask

   initial begin
      int drain_cycles;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.channel        <= '0;
      req_ch.rate           <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.pulses_per_rev <= '0;
      enc_ppr = PPR_RESET;
      for (int i = 0; i < TB_CHANNELS; i++) begin
         enc_acc[i]  = '0;
         enc_quad[i] = QUAD_FIRST;
         enc_rev[i]  = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_rate_extremes();
      test_zero_modulus();
      test_counter_out_of_range();
      test_output_hold_off();
      test_back_to_back();
      test_random_settings();

      stop_ticks();
      drain_cycles = 0;
      while (pending_pins_q.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_pins_q.size() != 0)
         report_mismatch($sformatf("%0d result items never arrived", pending_pins_q.size()));
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("quadrature_encoder_generator regression: pass");
      else
         $display("quadrature_encoder_generator regression: fail");
      $finish;
   end

endmodule
